// ===== rtl/acwe_pkg.sv =====
// Package for the ARP cache with expiry: opcodes, status codes, FSM states,
// controller/datapath command and status structs. No dependencies.
package acwe_pkg;
    localparam int unsigned CacheEntriesDefault = 8;
    localparam logic [31:0] ExpiryReset = 32'd60;
    localparam logic [10:0] ArpLength = 11'd15;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_MESSAGE = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    localparam logic CfgExpiry = 1'b0;
    localparam logic CfgMyIp = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE_RD,
        S_AGE_CHK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_WRITE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;        // capture the input item
        logic tick;        // advance the seconds counter
        logic clr_k;       // k := 0
        logic inc_k;       // k := k + 1
        logic rd_k;        // read slot k
        logic rd_last;     // read slot count-1
        logic wr_move;     // write moved entry to slot k, count -= 1
        logic scan_upd;    // update victim / hit from slot k
        logic wr_learn;    // write learned entry
        logic set_result;  // register the result
        logic out_valid;
    } t_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    len_ok;
        logic    k_lt_count;
        logic    stale;
        logic    hit;
    } t_sts;
endpackage

// ===== rtl/acwe_ctrl.sv =====
// Controller FSM of the ARP cache: sequences aging, scan and learn.
// Depends on acwe_pkg.
module acwe_ctrl import acwe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_k = 1'b1;
                    n_state = S_AGE_RD;
                end
            end
            S_AGE_RD: begin
                if (i_sts.opcode == OP_TICK) begin
                    o_cmd.tick = 1'b1;
                    o_cmd.set_result = 1'b1;
                    n_state = S_RESULT;
                end else if (i_sts.opcode == OP_NONE ||
                             (i_sts.opcode == OP_MESSAGE && !i_sts.len_ok)) begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_RESULT;
                end else if (i_sts.k_lt_count) begin
                    o_cmd.rd_k = 1'b1;
                    n_state = S_AGE_CHK;
                end else begin
                    o_cmd.clr_k = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_AGE_CHK: begin
                if (i_sts.stale) begin
                    o_cmd.rd_last = 1'b1;
                    n_state = S_MOVE_WR;
                end else begin
                    o_cmd.inc_k = 1'b1;
                    n_state = S_AGE_RD;
                end
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state = S_AGE_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.k_lt_count && !i_sts.hit) begin
                    o_cmd.rd_k = 1'b1;
                    n_state = S_SCAN_CHK;
                end else if (i_sts.opcode == OP_MESSAGE) begin
                    o_cmd.wr_learn = 1'b1;
                    n_state = S_WRITE;
                end else begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_SCAN_CHK: begin
                o_cmd.scan_upd = 1'b1;
                o_cmd.inc_k = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_WRITE: begin
                o_cmd.set_result = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/acwe_dp.sv =====
// Datapath of the ARP cache: entry memories, counters, item and result registers.
// Depends on acwe_pkg.
module acwe_dp import acwe_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = CacheEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_peer_ip,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_target_ip,
    input  logic        i_is_request,
    input  logic [10:0] i_payload_length,
    output logic [1:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic        o_reply_valid,
    output logic [31:0] o_reply_ip,
    output logic [47:0] o_reply_mac
);
    localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(CACHE_ENTRIES + 1);

    logic [31:0] r_mem_ip    [CACHE_ENTRIES];
    logic [47:0] r_mem_mac   [CACHE_ENTRIES];
    logic [31:0] r_mem_stamp [CACHE_ENTRIES];

    logic [31:0] r_expiry, r_my_ip, r_now;
    logic [CntW-1:0] r_count, r_k;
    logic [IdxW-1:0] r_victim;
    logic [31:0] r_victim_age;
    logic        r_hit;
    logic [47:0] r_hit_mac;
    logic [31:0] r_rd_ip, r_rd_stamp;
    logic [47:0] r_rd_mac;
    logic [1:0]  r_op;
    logic [31:0] r_peer_ip, r_target_ip;
    logic [47:0] r_sender_mac;
    logic        r_is_request;
    logic [10:0] r_len;

    logic [IdxW-1:0] k_idx, last_idx, rd_idx, wr_idx;
    logic [31:0] rd_age;
    logic        wr_en;
    logic [31:0] wr_ip, wr_stamp;
    logic [47:0] wr_mac;
    logic        reply;

    assign k_idx    = r_k[IdxW-1:0];
    assign last_idx = IdxW'(r_count - CntW'(1));
    assign rd_idx   = i_cmd.rd_last ? last_idx : k_idx;
    assign rd_age   = r_now - r_rd_stamp;
    assign reply    = r_is_request && (r_target_ip == r_my_ip);

    always_comb begin
        wr_en = i_cmd.wr_move || i_cmd.wr_learn;
        wr_ip = r_rd_ip;
        wr_mac = r_rd_mac;
        wr_stamp = r_rd_stamp;
        wr_idx = k_idx;
        if (i_cmd.wr_learn) begin
            wr_ip = r_peer_ip;
            wr_mac = r_sender_mac;
            wr_stamp = r_now;
            if (r_hit) begin
                wr_idx = r_victim;
            end else if (r_count >= CntW'(CACHE_ENTRIES)) begin
                wr_idx = r_victim;
            end else begin
                wr_idx = r_count[IdxW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_k || i_cmd.rd_last) begin
            r_rd_ip <= r_mem_ip[rd_idx];
            r_rd_mac <= r_mem_mac[rd_idx];
            r_rd_stamp <= r_mem_stamp[rd_idx];
        end
        if (wr_en) begin
            r_mem_ip[wr_idx] <= wr_ip;
            r_mem_mac[wr_idx] <= wr_mac;
            r_mem_stamp[wr_idx] <= wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= ExpiryReset;
            r_my_ip <= '0;
            r_now <= '0;
            r_count <= '0;
            r_k <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CfgExpiry) begin
                    r_expiry <= i_cfg_data;
                end else begin
                    r_my_ip <= i_cfg_data;
                end
            end
            if (i_cmd.tick) begin
                r_now <= r_now + 32'd1;
            end
            if (i_cmd.clr_k) begin
                r_k <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.inc_k) begin
                r_k <= r_k + CntW'(1);
            end
            if (i_cmd.wr_move) begin
                r_count <= r_count - CntW'(1);
            end
            if (i_cmd.wr_learn && !r_hit && r_count < CntW'(CACHE_ENTRIES)) begin
                r_count <= r_count + CntW'(1);
            end
            if (i_cmd.scan_upd && r_rd_ip == r_peer_ip) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_peer_ip <= i_peer_ip;
            r_sender_mac <= i_sender_mac;
            r_target_ip <= i_target_ip;
            r_is_request <= i_is_request;
            r_len <= i_payload_length;
        end
        if (i_cmd.scan_upd) begin
            if (r_rd_ip == r_peer_ip) begin
                r_victim <= k_idx;
                r_hit_mac <= r_rd_mac;
            end else if (r_k == '0 || rd_age > r_victim_age) begin
                r_victim <= k_idx;
                r_victim_age <= rd_age;
            end
        end
        if (i_cmd.set_result) begin
            o_status <= ST_DONE;
            o_found_mac <= '0;
            o_reply_valid <= 1'b0;
            o_reply_ip <= '0;
            o_reply_mac <= '0;
            case (t_opcode'(r_op))
                OP_LOOKUP: begin
                    o_status <= r_hit ? ST_FOUND : ST_MISS;
                    o_found_mac <= r_hit ? r_hit_mac : '0;
                end
                OP_MESSAGE: begin
                    if (r_len != ArpLength) begin
                        o_status <= ST_BAD_LEN;
                    end else if (reply) begin
                        o_reply_valid <= 1'b1;
                        o_reply_ip <= r_peer_ip;
                        o_reply_mac <= r_sender_mac;
                    end
                end
                default: begin
                    o_status <= ST_DONE;
                end
            endcase
        end
    end

    assign o_sts.opcode     = t_opcode'(r_op);
    assign o_sts.len_ok     = (r_len == ArpLength);
    assign o_sts.k_lt_count = (r_k < r_count);
    assign o_sts.stale      = (rd_age >= r_expiry);
    assign o_sts.hit        = r_hit;
endmodule

// ===== rtl/arp_cache_with_expiry_top.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         opcode, IPs, MAC, request flag, length
// result    out        o_valid / i_ready         status, found MAC, reply fields
// config    in         i_cfg_we (no wait)        index 0 expiry, 1 own IP
// A lookup first ages the table, then scans the live entries with a read and a check step
// each; a learn adds a write step, and each entry removed by aging adds a read, a check and
// a move step. A tick, a bad length or an unused opcode skips aging and the scan. The
// single-port entry memory and the controller's read/check steps set this sequence.
// Reset is synchronous and active low and empties the table at once.
// A result waits in its register until taken; the next item is accepted after that.
// Top level of the ARP cache with expiry. Depends on acwe_pkg, acwe_ctrl, acwe_dp.
module arp_cache_with_expiry_top import acwe_pkg::*; #(
    parameter int unsigned CACHE_ENTRIES = CacheEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_peer_ip,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_target_ip,
    input  logic        i_is_request,
    input  logic [10:0] i_payload_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic        o_reply_valid,
    output logic [31:0] o_reply_ip,
    output logic [47:0] o_reply_mac,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    acwe_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .i_sts(sts), .o_cmd(cmd)
    );

    assign o_valid = cmd.out_valid;

    acwe_dp #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_peer_ip(i_peer_ip), .i_sender_mac(i_sender_mac),
        .i_target_ip(i_target_ip), .i_is_request(i_is_request),
        .i_payload_length(i_payload_length),
        .o_status(o_status), .o_found_mac(o_found_mac), .o_reply_valid(o_reply_valid),
        .o_reply_ip(o_reply_ip), .o_reply_mac(o_reply_mac)
    );
endmodule

// ===== rtl/acwe_checker.sv =====
// Port-level checker for the ARP cache top level, with its bind statement.
// Depends on acwe_pkg and arp_cache_with_expiry_top.
module acwe_checker import acwe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [47:0] o_found_mac,
    input logic        o_reply_valid
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while a result is pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready again right after an accepted item");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");
    a_mac_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FOUND |-> o_found_mac == '0)
        else $error("MAC without a hit");
    a_reply_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reply_valid |-> o_status == ST_DONE)
        else $error("reply with wrong status");
endmodule

bind arp_cache_with_expiry_top acwe_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_found_mac(o_found_mac), .o_reply_valid(o_reply_valid)
);
